@@ rtl/core/pcfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfc_pkg: shared types and constants of the pyro channel fire controller
// Opcodes, channel states, command record passed from the decoder to the
// execution unit, register indexes and mode codes.
// ----------------------------------------------------------------------------
package pcfc_pkg;

    localparam int MAX_CH    = 4;
    localparam int CH_IDX_W  = 2;
    localparam int TICK_W    = 16;
    localparam int SAMPLE_W  = 12;

    // command queue between decoder and execution unit
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_ARM     = 3'd1,
        OP_DISARM  = 3'd2,
        OP_FIRE    = 3'd3,
        OP_ESTOP   = 3'd4,
        OP_RESET   = 3'd5,
        OP_CONT    = 3'd6,
        OP_QUERY   = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_SAFE    = 2'd0,
        ST_ARMED   = 2'd1,
        ST_FIRING  = 2'd2,
        ST_FIRED   = 2'd3
    } t_chan_st;

    localparam logic [2:0] CS_INVALID = 3'd4;

    // arm switch modes; code 3 never arms
    localparam logic [1:0] ARM_SW_NONE = 2'd0;
    localparam logic [1:0] ARM_SW_HIGH = 2'd1;
    localparam logic [1:0] ARM_SW_LOW  = 2'd2;

    // continuity sense modes; code 3 acts as none
    localparam logic [1:0] SENSE_DIGITAL = 2'd1;
    localparam logic [1:0] SENSE_ANALOG  = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_FIRE_TIME0 = 3'd0;
    localparam logic [2:0] REG_FIRE_TIME3 = 3'd3;
    localparam logic [2:0] REG_THRESHOLD  = 3'd4;
    localparam logic [2:0] REG_SENSE_MODE = 3'd5;
    localparam logic [2:0] REG_ARM_MODE   = 3'd6;

    typedef logic [MAX_CH-1:0][TICK_W-1:0] t_fire_times;

    // decoded command
    typedef struct packed {
        t_opcode              op;
        logic [CH_IDX_W-1:0]  idx;
        logic                 ok;       // channel below channel count
        logic                 arm_ok;   // arm switch active
        logic                 cont_wr;  // continuity store takes a new bit
        logic                 cont_val; // that bit
        logic                 cb_en;    // addressed channel has sensing
    } t_cmd;

endpackage

@@ rtl/core/pcfc_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfc_decode: front end
// Accepts input transfers and turns them into commands for the queue:
// channel check, arm switch gating and continuity evaluation.
// ----------------------------------------------------------------------------
module pcfc_decode import pcfc_pkg::*; #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [2:0]           i_opcode,
    input  logic [3:0]           i_channel,
    input  logic                 i_arm_switch_level,
    input  logic [SAMPLE_W-1:0]  i_adc_sample,
    input  logic                 i_sample_valid,
    input  logic                 i_digital_level,
    input  logic [SAMPLE_W-1:0]  i_threshold,
    input  logic [7:0]           i_sense_mode,
    input  logic [1:0]           i_arm_mode,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic [CH_IDX_W-1:0] idx;
    logic [1:0]          mode;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign idx  = i_channel[CH_IDX_W-1:0];
    assign mode = i_sense_mode[{idx, 1'b0} +: 2];

    always_comb begin
        o_cmd     = '0;
        o_cmd.op  = t_opcode'(i_opcode);
        o_cmd.idx = idx;
        o_cmd.ok  = (i_channel < 4'(NUM_CHANNELS));
        case (i_arm_mode)
            ARM_SW_NONE: o_cmd.arm_ok = 1'b1;
            ARM_SW_HIGH: o_cmd.arm_ok = i_arm_switch_level;
            ARM_SW_LOW:  o_cmd.arm_ok = !i_arm_switch_level;
            default:     o_cmd.arm_ok = 1'b0;
        endcase
        o_cmd.cb_en    = (mode == SENSE_DIGITAL) || (mode == SENSE_ANALOG);
        o_cmd.cont_wr  = (mode == SENSE_DIGITAL) || ((mode == SENSE_ANALOG) && i_sample_valid);
        o_cmd.cont_val = (mode == SENSE_DIGITAL) ? i_digital_level
                                                 : (i_adc_sample > i_threshold);
    end

endmodule

@@ rtl/core/pcfc_cmd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfc_cmd_queue: command queue
// Small FIFO that decouples the decoder from the execution unit.
// ----------------------------------------------------------------------------
module pcfc_cmd_queue import pcfc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    output logic  o_nempty,
    input  logic  i_pop,
    output t_cmd  o_cmd
);

    t_cmd                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wptr, n_wptr;
    logic [Q_PTR_W-1:0]  r_rptr, n_rptr;
    logic [Q_CNT_W-1:0]  r_count, n_count;

    assign o_full   = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_nempty = (r_count != '0);
    assign o_cmd    = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr + (i_push ? Q_PTR_W'(1) : '0);
        n_rptr  = r_rptr + (i_pop ? Q_PTR_W'(1) : '0);
        n_count = r_count + (i_push ? Q_CNT_W'(1) : '0) - (i_pop ? Q_CNT_W'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

@@ rtl/core/pcfc_exec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfc_exec: back end
// Holds the channel state, applies one command per cycle while the result
// register is free of a stalled result, and registers the result transfer.
// ----------------------------------------------------------------------------
module pcfc_exec import pcfc_pkg::*; #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_nempty,
    input  t_cmd         i_cmd,
    output logic         o_pop,
    input  t_fire_times  i_fire_time,
    output logic         o_valid,
    input  logic         i_stall,
    output logic         o_status,
    output logic [3:0]   o_fire_outputs,
    output logic [2:0]   o_chan_state,
    output logic         o_arm_flag,
    output logic [3:0]   o_continuity_mask,
    output logic         o_continuity_bit
);

    t_chan_st            r_st   [NUM_CHANNELS];
    t_chan_st            n_st   [NUM_CHANNELS];
    logic [TICK_W-1:0]   r_el   [NUM_CHANNELS];
    logic [TICK_W-1:0]   n_el   [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_cont, n_cont;
    logic                r_armed, n_armed;

    logic                r_out_valid;
    logic                r_status,  n_status;
    logic [3:0]          r_fo,      n_fo;
    logic [2:0]          r_cs,      n_cs;
    logic [3:0]          r_cm,      n_cm;
    logic                r_cb,      n_cb;

    t_chan_st            cur_st;
    logic                out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = i_q_nempty && out_free;

    // state of the addressed channel before the command
    always_comb begin
        cur_st = ST_SAFE;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (i_cmd.idx == CH_IDX_W'(c)) begin
                cur_st = r_st[c];
            end
        end
    end

    always_comb begin
        logic [TICK_W-1:0] inc;
        logic              sel;
        n_armed  = r_armed;
        n_cont   = r_cont;
        n_status = 1'b0;
        inc      = '0;
        sel      = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            n_st[c] = r_st[c];
            n_el[c] = r_el[c];
        end

        case (i_cmd.op)
            OP_ARM: begin
                n_status = !i_cmd.arm_ok;
                if (i_cmd.arm_ok) begin
                    n_armed = 1'b1;
                end
            end
            OP_DISARM, OP_ESTOP: n_armed = 1'b0;
            OP_FIRE: n_status = !(i_cmd.ok && cur_st == ST_ARMED && r_armed);
            OP_RESET, OP_CONT, OP_QUERY: n_status = !i_cmd.ok;
            default: n_status = 1'b0;
        endcase

        for (int c = 0; c < NUM_CHANNELS; c++) begin
            sel = i_cmd.ok && (i_cmd.idx == CH_IDX_W'(c));
            inc = (r_el[c] == '1) ? r_el[c] : r_el[c] + TICK_W'(1);
            case (i_cmd.op)
                OP_TICK: begin
                    if (r_st[c] == ST_FIRING) begin
                        n_el[c] = inc;
                        if (inc >= i_fire_time[c]) begin
                            n_st[c] = ST_FIRED;
                        end
                    end
                end
                OP_ARM: begin
                    if (i_cmd.arm_ok && r_st[c] == ST_SAFE) begin
                        n_st[c] = ST_ARMED;
                    end
                end
                OP_DISARM: begin
                    if (r_st[c] == ST_ARMED || r_st[c] == ST_FIRING) begin
                        n_st[c] = ST_SAFE;
                    end
                end
                OP_FIRE: begin
                    if (sel && r_st[c] == ST_ARMED && r_armed) begin
                        n_st[c] = ST_FIRING;
                        n_el[c] = '0;
                    end
                end
                OP_ESTOP: n_st[c] = ST_SAFE;
                OP_RESET: begin
                    if (sel) begin
                        n_st[c] = ST_SAFE;
                        n_el[c] = '0;
                    end
                end
                OP_CONT: begin
                    if (sel && i_cmd.cont_wr) begin
                        n_cont[c] = i_cmd.cont_val;
                    end
                end
                default: ;
            endcase
        end
    end

    // result fields, taken from the state after the command
    always_comb begin
        n_fo = '0;
        n_cm = '0;
        n_cs = CS_INVALID;
        n_cb = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            n_fo[c] = (n_st[c] == ST_FIRING);
            n_cm[c] = n_cont[c];
            if (i_cmd.ok && i_cmd.idx == CH_IDX_W'(c)) begin
                n_cs = {1'b0, n_st[c]};
                n_cb = i_cmd.cb_en && n_cont[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_st[c] <= ST_SAFE;
                r_el[c] <= '0;
            end
            r_cont      <= '0;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    r_st[c] <= n_st[c];
                    r_el[c] <= n_el[c];
                end
                r_cont      <= n_cont;
                r_armed     <= n_armed;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_fo     <= n_fo;
            r_cs     <= n_cs;
            r_cm     <= n_cm;
            r_cb     <= n_cb;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_status;
    assign o_fire_outputs      = r_fo;
    assign o_chan_state        = r_cs;
    assign o_arm_flag          = r_armed;
    assign o_continuity_mask   = r_cm;
    assign o_continuity_bit    = r_cb;

endmodule

@@ rtl/core/pyro_channel_fire_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pyro_channel_fire_controller: multi-channel pyro firing controller
// Per-channel safe/armed/firing/fired sequencing with global arming,
// millisecond firing timers and continuity sensing.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ---------------------------------
//  command   in         i_valid / o_stall    opcode, channel, switch, adc,...
//  result    out        o_valid / i_stall    status, fire outputs, state,...
//  config    in         APB psel/penable     seven registers at 4*index
//
//  One transfer per cycle sustained while the result side does not stall; a
//  command is decoded into the queue at its transfer edge and executed from
//  the queue into the result register once that register is free.
//  The execution unit updates all channels in parallel with one 16-bit
//  increment and compare per channel.
//  Synchronous active-low reset: all channels safe, timers and continuity
//  cleared, registers at their defaults. No clearing pass.
//  A stalled result holds in the output register; the two-entry queue keeps
//  taking commands until it fills, then o_stall rises.
//
// ----------------------------------------------------------------------------
module pyro_channel_fire_controller import pcfc_pkg::*; #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [2:0]           i_opcode,
    input  logic [3:0]           i_channel,
    input  logic                 i_arm_switch_level,
    input  logic [SAMPLE_W-1:0]  i_adc_sample,
    input  logic                 i_sample_valid,
    input  logic                 i_digital_level,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_status,
    output logic [3:0]           o_fire_outputs,
    output logic [2:0]           o_chan_state,
    output logic                 o_arm_flag,
    output logic [3:0]           o_continuity_mask,
    output logic                 o_continuity_bit,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // ---- configuration registers ----
    t_fire_times           r_fire_time;
    logic [SAMPLE_W-1:0]   r_threshold;
    logic [7:0]            r_sense_mode;
    logic [1:0]            r_arm_mode;

    logic [2:0]            reg_idx;
    logic                  reg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign reg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_CH; c++) begin
                r_fire_time[c] <= TICK_W'(1000);
            end
            r_threshold  <= SAMPLE_W'(2048);
            r_sense_mode <= '0;
            r_arm_mode   <= ARM_SW_NONE;
        end else if (reg_wr) begin
            if (reg_idx inside {[REG_FIRE_TIME0:REG_FIRE_TIME3]}) begin
                r_fire_time[reg_idx[CH_IDX_W-1:0]] <= pwdata[TICK_W-1:0];
            end else if (reg_idx == REG_THRESHOLD) begin
                r_threshold <= pwdata[SAMPLE_W-1:0];
            end else if (reg_idx == REG_SENSE_MODE) begin
                r_sense_mode <= pwdata[7:0];
            end else if (reg_idx == REG_ARM_MODE) begin
                r_arm_mode <= pwdata[1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx inside {[REG_FIRE_TIME0:REG_FIRE_TIME3]}) begin
            prdata = {16'd0, r_fire_time[reg_idx[CH_IDX_W-1:0]]};
        end else if (reg_idx == REG_THRESHOLD) begin
            prdata = {20'd0, r_threshold};
        end else if (reg_idx == REG_SENSE_MODE) begin
            prdata = {24'd0, r_sense_mode};
        end else if (reg_idx == REG_ARM_MODE) begin
            prdata = {30'd0, r_arm_mode};
        end
    end

    // ---- front: decode into the queue ----
    t_cmd  dec_cmd;
    t_cmd  q_cmd;
    logic  q_push, q_pop, q_full, q_nempty;

    pcfc_decode #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_decode (
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_opcode           (i_opcode),
        .i_channel          (i_channel),
        .i_arm_switch_level (i_arm_switch_level),
        .i_adc_sample       (i_adc_sample),
        .i_sample_valid     (i_sample_valid),
        .i_digital_level    (i_digital_level),
        .i_threshold        (r_threshold),
        .i_sense_mode       (r_sense_mode),
        .i_arm_mode         (r_arm_mode),
        .i_q_full           (q_full),
        .o_push             (q_push),
        .o_cmd              (dec_cmd)
    );

    pcfc_cmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_cmd    (dec_cmd),
        .o_full   (q_full),
        .o_nempty (q_nempty),
        .i_pop    (q_pop),
        .o_cmd    (q_cmd)
    );

    // ---- back: channel state and result register ----
    pcfc_exec #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_exec (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_nempty          (q_nempty),
        .i_cmd               (q_cmd),
        .o_pop               (q_pop),
        .i_fire_time         (r_fire_time),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_fire_outputs      (o_fire_outputs),
        .o_chan_state        (o_chan_state),
        .o_arm_flag          (o_arm_flag),
        .o_continuity_mask   (o_continuity_mask),
        .o_continuity_bit    (o_continuity_bit)
    );

endmodule

@@ rtl/core/pcfc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfc_checker: port-level checks of the fire controller
// Watches the result channel for handshake and consistency rules.
// ----------------------------------------------------------------------------
module pcfc_checker import pcfc_pkg::*; #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [3:0]  o_fire_outputs,
    input  logic [2:0]  o_chan_state,
    input  logic        o_arm_flag,
    input  logic        o_continuity_bit
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // nothing fires unless the system is armed
    a_fire_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_fire_outputs != 4'd0) |-> o_arm_flag)
        else $error("channel firing while disarmed");

    // no fire output for channels that do not exist
    a_fire_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_fire_outputs >> NUM_CHANNELS) == 4'd0))
        else $error("fire output beyond channel count");

    // an addressed firing channel shows on its fire output
    a_firing_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_chan_state == {1'b0, ST_FIRING}) |-> (o_fire_outputs != 4'd0))
        else $error("firing state without fire output");

    // invalid channel reports no continuity and a set status bit is allowed
    a_invalid_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_chan_state == CS_INVALID) |-> !o_continuity_bit)
        else $error("continuity reported for invalid channel");

endmodule

bind pyro_channel_fire_controller pcfc_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_pcfc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_fire_outputs      (o_fire_outputs),
    .o_chan_state        (o_chan_state),
    .o_arm_flag          (o_arm_flag),
    .o_continuity_bit    (o_continuity_bit)
);

@@ verif/fire_ctrl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fire_ctrl_checker: result checker for the pyro channel fire controller
// Tracks channel sequencing from observed command transfers and register
// writes, and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module fire_ctrl_checker import pcfc_pkg::*; #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 i_cmd_valid,
    input  logic                 i_cmd_stall,
    input  logic [2:0]           i_opcode,
    input  logic [3:0]           i_channel,
    input  logic                 i_arm_switch_level,
    input  logic [SAMPLE_W-1:0]  i_adc_sample,
    input  logic                 i_sample_valid,
    input  logic                 i_digital_level,
    // result channel
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic                 i_status,
    input  logic [3:0]           i_fire_outputs,
    input  logic [2:0]           i_chan_state,
    input  logic                 i_arm_flag,
    input  logic [3:0]           i_continuity_mask,
    input  logic                 i_continuity_bit,
    // configuration port
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [4:0]           i_paddr,
    input  logic [31:0]          i_pwdata,
    input  logic                 i_pready,
    // to the testbench top
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_checked
);

    typedef struct packed {
        logic        status;
        logic [3:0]  fire;
        logic [2:0]  state;
        logic        armed;
        logic [3:0]  cmask;
        logic        cbit;
    } t_fire_report;

    // mirrored channel state
    t_chan_st              chan_st [MAX_CH];
    logic [TICK_W-1:0]     elapsed [MAX_CH];
    logic [MAX_CH-1:0]     cont;
    logic                  sys_armed;

    // mirrored registers
    logic [TICK_W-1:0]     duration [MAX_CH];
    logic [SAMPLE_W-1:0]   thresh;
    logic [7:0]            sense;
    logic [1:0]            arm_mode;

    t_fire_report          awaited_reports [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    function automatic logic [1:0] sense_of(input logic [CH_IDX_W-1:0] c);
        return sense[2*c +: 2];
    endfunction

    task automatic clear_model();
        for (int c = 0; c < MAX_CH; c++) begin
            chan_st[c]  = ST_SAFE;
            elapsed[c]  = '0;
            duration[c] = 16'd1000;
        end
        cont      = '0;
        sys_armed = 1'b0;
        thresh    = 12'd2048;
        sense     = '0;
        arm_mode  = ARM_SW_NONE;
        awaited_reports.delete();
    endtask

    task automatic apply_command(input logic [2:0] op_bits, input logic [3:0] ch,
                                 input logic sw, input logic [SAMPLE_W-1:0] smp,
                                 input logic sv, input logic lvl,
                                 output t_fire_report r);
        logic                ok;
        logic                active;
        logic [1:0]          m;
        logic [CH_IDX_W-1:0] ix;
        ok = int'(ch) < NUM_CHANNELS;
        ix = ch[CH_IDX_W-1:0];
        r  = '0;
        case (t_opcode'(op_bits))
            OP_TICK: begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    if (chan_st[c] == ST_FIRING) begin
                        if (elapsed[c] != '1)
                            elapsed[c] = elapsed[c] + 1'b1;
                        if (elapsed[c] >= duration[c])
                            chan_st[c] = ST_FIRED;
                    end
                end
            end
            OP_ARM: begin
                case (arm_mode)
                    ARM_SW_NONE: active = 1'b1;
                    ARM_SW_HIGH: active = sw;
                    ARM_SW_LOW:  active = !sw;
                    default:     active = 1'b0;
                endcase
                if (!active) begin
                    r.status = 1'b1;
                end else begin
                    for (int c = 0; c < NUM_CHANNELS; c++)
                        if (chan_st[c] == ST_SAFE)
                            chan_st[c] = ST_ARMED;
                    sys_armed = 1'b1;
                end
            end
            OP_DISARM: begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                    if (chan_st[c] == ST_ARMED || chan_st[c] == ST_FIRING)
                        chan_st[c] = ST_SAFE;
                sys_armed = 1'b0;
            end
            OP_FIRE: begin
                if (!ok) begin
                    r.status = 1'b1;
                end else if (chan_st[ix] != ST_ARMED || !sys_armed) begin
                    r.status = 1'b1;
                end else begin
                    chan_st[ix] = ST_FIRING;
                    elapsed[ix] = '0;
                end
            end
            OP_ESTOP: begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                    chan_st[c] = ST_SAFE;
                sys_armed = 1'b0;
            end
            OP_RESET: begin
                if (!ok) begin
                    r.status = 1'b1;
                end else begin
                    chan_st[ix] = ST_SAFE;
                    elapsed[ix] = '0;
                end
            end
            OP_CONT: begin
                if (!ok) begin
                    r.status = 1'b1;
                end else begin
                    m = sense_of(ix);
                    if (m == SENSE_DIGITAL)
                        cont[ix] = lvl;
                    else if (m == SENSE_ANALOG && sv)
                        cont[ix] = smp > thresh;
                end
            end
            default: begin
                if (!ok)
                    r.status = 1'b1;
            end
        endcase

        for (int c = 0; c < NUM_CHANNELS; c++) begin
            r.fire[c]  = chan_st[c] == ST_FIRING;
            r.cmask[c] = cont[c];
        end
        r.state = CS_INVALID;
        if (ok) begin
            r.state = {1'b0, chan_st[ix]};
            m = sense_of(ix);
            r.cbit = (m == SENSE_DIGITAL || m == SENSE_ANALOG) ? cont[ix] : 1'b0;
        end
        r.armed = sys_armed;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] checker: %s got %0d expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    task automatic check_report(input t_fire_report got);
        t_fire_report want;
        want = awaited_reports.pop_front();
        o_checked++;
        if (got.status !== want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
        if (got.fire !== want.fire)
            report_mismatch("fire_outputs", int'(got.fire), int'(want.fire));
        if (got.state !== want.state)
            report_mismatch("chan_state", int'(got.state), int'(want.state));
        if (got.armed !== want.armed)
            report_mismatch("arm_flag", int'(got.armed), int'(want.armed));
        if (got.cmask !== want.cmask)
            report_mismatch("cont_mask", int'(got.cmask), int'(want.cmask));
        if (got.cbit !== want.cbit)
            report_mismatch("cont_bit", int'(got.cbit), int'(want.cbit));
    endtask

    always @(posedge i_clk) begin
        t_fire_report r;
        logic [2:0]   idx;
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                idx = i_paddr[4:2];
                if (idx <= REG_FIRE_TIME3)
                    duration[idx[CH_IDX_W-1:0]] = i_pwdata[TICK_W-1:0];
                else if (idx == REG_THRESHOLD)
                    thresh = i_pwdata[SAMPLE_W-1:0];
                else if (idx == REG_SENSE_MODE)
                    sense = i_pwdata[7:0];
                else if (idx == REG_ARM_MODE)
                    arm_mode = i_pwdata[1:0];
            end
            // results leave only after their command has been registered, so check first
            if (i_res_valid && !i_res_stall) begin
                r = {i_status, i_fire_outputs, i_chan_state, i_arm_flag,
                     i_continuity_mask, i_continuity_bit};
                if (awaited_reports.size() == 0)
                    report_mismatch("result with none awaited, status", int'(i_status), 0);
                else
                    check_report(r);
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                apply_command(i_opcode, i_channel, i_arm_switch_level, i_adc_sample,
                              i_sample_valid, i_digital_level, r);
                awaited_reports.push_back(r);
            end
        end
        o_pending <= awaited_reports.size();
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the pyro channel fire controller
// Drives command transfers and APB register writes, stalls the result side
// at random, and leaves prediction and comparison to fire_ctrl_checker.
// ----------------------------------------------------------------------------
module tb;
    import pcfc_pkg::*;

    localparam int N_CH = 4;

    // codes the package leaves unnamed
    localparam logic [1:0] SENSE_OFF    = 2'd0;
    localparam logic [1:0] SENSE_UNUSED = 2'd3;   // acts as no sensing
    localparam logic [1:0] ARM_SW_NEVER = 2'd3;   // arm always refused

    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int PHASE_ITEMS = 270;

    logic                i_clk              = 1'b0;
    logic                i_rst_n            = 1'b0;
    logic                i_valid            = 1'b0;
    logic [2:0]          i_opcode           = '0;
    logic [3:0]          i_channel          = '0;
    logic                i_arm_switch_level = 1'b0;
    logic [SAMPLE_W-1:0] i_adc_sample       = '0;
    logic                i_sample_valid     = 1'b0;
    logic                i_digital_level    = 1'b0;
    logic                i_stall            = 1'b0;
    logic                psel               = 1'b0;
    logic                penable            = 1'b0;
    logic                pwrite             = 1'b0;
    logic [4:0]          paddr              = '0;
    logic [31:0]         pwdata             = '0;

    logic                o_stall;
    logic                o_valid;
    logic                o_status;
    logic [3:0]          o_fire_outputs;
    logic [2:0]          o_chan_state;
    logic                o_arm_flag;
    logic [3:0]          o_continuity_mask;
    logic                o_continuity_bit;
    logic [31:0]         prdata;
    logic                pready;

    int errors;
    int pending;
    int checked;

    // stimulus knobs, percent of cycles
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_seq      = 0;   // bump to request a long receiver hold-off
    int sent_total    = 0;
    int phase_count   = 0;

    // current register copies, used to aim samples and switch levels
    logic [SAMPLE_W-1:0] cur_thresh   = 12'd2048;
    logic [1:0]          cur_arm_mode = ARM_SW_NONE;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    pyro_channel_fire_controller #(
        .NUM_CHANNELS (N_CH)
    ) i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_opcode            (i_opcode),
        .i_channel           (i_channel),
        .i_arm_switch_level  (i_arm_switch_level),
        .i_adc_sample        (i_adc_sample),
        .i_sample_valid      (i_sample_valid),
        .i_digital_level     (i_digital_level),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_fire_outputs      (o_fire_outputs),
        .o_chan_state        (o_chan_state),
        .o_arm_flag          (o_arm_flag),
        .o_continuity_mask   (o_continuity_mask),
        .o_continuity_bit    (o_continuity_bit),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    fire_ctrl_checker #(
        .NUM_CHANNELS (N_CH)
    ) u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd_valid         (i_valid),
        .i_cmd_stall         (o_stall),
        .i_opcode            (i_opcode),
        .i_channel           (i_channel),
        .i_arm_switch_level  (i_arm_switch_level),
        .i_adc_sample        (i_adc_sample),
        .i_sample_valid      (i_sample_valid),
        .i_digital_level     (i_digital_level),
        .i_res_valid         (o_valid),
        .i_res_stall         (i_stall),
        .i_status            (o_status),
        .i_fire_outputs      (o_fire_outputs),
        .i_chan_state        (o_chan_state),
        .i_arm_flag          (o_arm_flag),
        .i_continuity_mask   (o_continuity_mask),
        .i_continuity_bit    (o_continuity_bit),
        .i_psel              (psel),
        .i_penable           (penable),
        .i_pwrite            (pwrite),
        .i_paddr             (paddr),
        .i_pwdata            (pwdata),
        .i_pready            (pready),
        .o_errors            (errors),
        .o_pending           (pending),
        .o_checked           (checked)
    );

    // Result-side stall. A bump of hold_seq starts a long hold-off counted here,
    // while the sender keeps offering; the queue fills and o_stall must rise.
    int hold_left = 0;
    int hold_seen = 0;
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one command and wait for its transfer. Valid stays high on return;
    // the next call (or drain) decides what happens in the same time step.
    task automatic send_cmd(input t_opcode op, input logic [3:0] ch, input logic sw,
                            input logic [SAMPLE_W-1:0] smp, input logic sv,
                            input logic lvl);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_opcode           <= op;
        i_channel          <= ch;
        i_arm_switch_level <= sw;
        i_adc_sample       <= smp;
        i_sample_valid     <= sv;
        i_digital_level    <= lvl;
        do @(posedge i_clk); while (o_stall);
        sent_total++;
    endtask

    // Lower valid, then wait until every awaited result has been checked and let
    // the two-stage pipe settle. pending is registered, hence do-while.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Only called with the block idle (after reset or after drain).
    task automatic configure(input logic [15:0] d0, input logic [15:0] d1,
                             input logic [15:0] d2, input logic [15:0] d3,
                             input logic [SAMPLE_W-1:0] thr, input logic [7:0] sns,
                             input logic [1:0] arm);
        apb_write(REG_FIRE_TIME0,         {16'h0, d0});
        apb_write(3'(REG_FIRE_TIME0 + 1), {16'h0, d1});
        apb_write(3'(REG_FIRE_TIME0 + 2), {16'h0, d2});
        apb_write(REG_FIRE_TIME3,         {16'h0, d3});
        apb_write(REG_THRESHOLD,          {20'h0, thr});
        apb_write(REG_SENSE_MODE,         {24'h0, sns});
        apb_write(REG_ARM_MODE,           {30'h0, arm});
        cur_thresh   = thr;
        cur_arm_mode = arm;
    endtask

    // mostly live channels, sometimes an out-of-range index
    function automatic logic [3:0] pick_channel();
        if ($urandom_range(99) < 85)
            return 4'($urandom_range(N_CH - 1));
        return 4'($urandom_range(15));
    endfunction

    // samples cluster around the threshold edge and the rails
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return cur_thresh;
            3:       return cur_thresh + 1'b1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic issue(input t_opcode op, input logic [3:0] ch, input logic sw);
        send_cmd(op, ch, sw, pick_sample(), $urandom_range(99) < 80,
                 1'($urandom_range(1)));
    endtask

    // arm, fire a few, sense, run the timers, query, then mostly some way of making safe
    task automatic run_sequence();
        logic sw_on;
        case (cur_arm_mode)
            ARM_SW_HIGH: sw_on = 1'b1;
            ARM_SW_LOW:  sw_on = 1'b0;
            default:     sw_on = 1'($urandom_range(1));
        endcase
        if ($urandom_range(9) == 0)
            sw_on = !sw_on;
        issue(OP_ARM, pick_channel(), sw_on);
        repeat ($urandom_range(1, 4))
            issue(OP_FIRE, 4'($urandom_range(N_CH - 1)), 1'($urandom_range(1)));
        repeat ($urandom_range(0, 3))
            issue(OP_CONT, pick_channel(), 1'($urandom_range(1)));
        repeat ($urandom_range(1, 10))
            issue(OP_TICK, pick_channel(), 1'($urandom_range(1)));
        issue(OP_QUERY, pick_channel(), 1'($urandom_range(1)));
        case ($urandom_range(3))
            0: issue(OP_DISARM, pick_channel(), 1'($urandom_range(1)));
            1: issue(OP_ESTOP, pick_channel(), 1'($urandom_range(1)));
            2: issue(OP_RESET, pick_channel(), 1'($urandom_range(1)));
            default: ;
        endcase
    endtask

    task automatic run_phase(input int n_items, input int send_pct, input int recv_pct,
                             input bit pressure);
        int  start;
        bit  hold_done;
        bit  pause_done;
        start         = sent_total;
        hold_done     = 1'b0;
        pause_done    = 1'b0;
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        phase_count++;
        while (sent_total - start < n_items) begin
            if (pressure && !hold_done && sent_total - start > n_items / 3) begin
                hold_seq++;
                hold_done = 1'b1;
            end
            if (pressure && !pause_done && sent_total - start > 2 * n_items / 3) begin
                // sender pauses until the block has handed back everything
                drain();
                pause_done = 1'b1;
            end
            if ($urandom_range(99) < 70) begin
                run_sequence();
            end else begin
                repeat ($urandom_range(1, 4))
                    issue(t_opcode'($urandom_range(7)), pick_channel(),
                          1'($urandom_range(1)));
            end
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ch0 ends on the first tick (zero duration), ch3 runs long,
        // ch1 digital sensing, ch2 analog, ch3 on the unused sense code.
        configure(16'd0, 16'd1, 16'd2, 16'hFFFF, 12'd2048,
                  {SENSE_UNUSED, SENSE_ANALOG, SENSE_DIGITAL, SENSE_OFF}, ARM_SW_NONE);
        send_cmd(OP_QUERY,  4'd15, 1'b0, 12'h000, 1'b0, 1'b0); // bad channel
        send_cmd(OP_FIRE,   4'd0,  1'b0, 12'h000, 1'b0, 1'b0); // not armed
        send_cmd(OP_TICK,   4'd9,  1'b0, 12'h000, 1'b0, 1'b0); // global op, bad channel
        send_cmd(OP_ARM,    4'd15, 1'b1, 12'hFFF, 1'b1, 1'b1);
        send_cmd(OP_FIRE,   4'd0,  1'b0, 12'h000, 1'b0, 1'b0);
        send_cmd(OP_FIRE,   4'd1,  1'b0, 12'h000, 1'b0, 1'b0);
        send_cmd(OP_FIRE,   4'd2,  1'b0, 12'h000, 1'b0, 1'b0);
        send_cmd(OP_FIRE,   4'd3,  1'b0, 12'h000, 1'b0, 1'b0);
        send_cmd(OP_FIRE,   4'd5,  1'b0, 12'h000, 1'b0, 1'b0); // bad channel
        send_cmd(OP_TICK,   4'd0,  1'b0, 12'h000, 1'b0, 1'b0);
        send_cmd(OP_TICK,   4'd2,  1'b0, 12'h000, 1'b0, 1'b0);
        send_cmd(OP_CONT,   4'd1,  1'b0, 12'h000, 1'b0, 1'b1); // digital
        send_cmd(OP_CONT,   4'd2,  1'b0, 12'hFFF, 1'b1, 1'b0); // above threshold
        send_cmd(OP_CONT,   4'd2,  1'b0, 12'd2048, 1'b1, 1'b0); // equal: no continuity
        send_cmd(OP_CONT,   4'd2,  1'b0, 12'hFFF, 1'b0, 1'b0); // failed conversion
        send_cmd(OP_CONT,   4'd0,  1'b0, 12'hFFF, 1'b1, 1'b1); // no sensing
        send_cmd(OP_CONT,   4'd3,  1'b0, 12'hFFF, 1'b1, 1'b1); // unused sense code
        send_cmd(OP_CONT,   4'd12, 1'b0, 12'hFFF, 1'b1, 1'b1); // bad channel
        send_cmd(OP_RESET,  4'd4,  1'b0, 12'h000, 1'b0, 1'b0); // bad channel
        send_cmd(OP_DISARM, 4'd0,  1'b0, 12'h000, 1'b0, 1'b0); // firing ch3 to safe
        send_cmd(OP_FIRE,   4'd2,  1'b0, 12'h000, 1'b0, 1'b0); // fired, refused
        send_cmd(OP_ARM,    4'd0,  1'b0, 12'h000, 1'b0, 1'b0); // fired stay fired
        send_cmd(OP_RESET,  4'd1,  1'b0, 12'h000, 1'b0, 1'b0);
        send_cmd(OP_ESTOP,  4'd7,  1'b0, 12'h000, 1'b0, 1'b0); // clears fired too
        send_cmd(OP_QUERY,  4'd2,  1'b0, 12'h000, 1'b0, 1'b0);
        drain();

        // Random phases: one flow-control mix and one register setting each.
        configure(16'($urandom_range(6)), 16'($urandom_range(6)), 16'($urandom_range(6)),
                  16'($urandom_range(6)), 12'($urandom), 8'($urandom), ARM_SW_NONE);
        run_phase(PHASE_ITEMS, 0, 0, 1'b1);

        configure(16'($urandom_range(6)), 16'($urandom_range(6)), 16'($urandom_range(6)),
                  16'($urandom_range(6)), 12'($urandom), 8'($urandom), ARM_SW_HIGH);
        run_phase(PHASE_ITEMS, 83, 0, 1'b0);

        configure(16'($urandom_range(6)), 16'($urandom_range(6)), 16'($urandom_range(6)),
                  16'($urandom_range(6)), 12'($urandom), 8'($urandom), ARM_SW_LOW);
        run_phase(PHASE_ITEMS, 0, 83, 1'b0);

        configure(16'($urandom_range(6)), 16'($urandom_range(6)), 16'($urandom_range(6)),
                  16'($urandom_range(6)), 12'($urandom), 8'($urandom), ARM_SW_NEVER);
        run_phase(PHASE_ITEMS, 20, 20, 1'b0);

        // register extremes: zero and full-scale durations, zero threshold
        configure(16'd0, 16'hFFFF, 16'd1, 16'd3, 12'd0,
                  {SENSE_ANALOG, SENSE_DIGITAL, SENSE_ANALOG, SENSE_DIGITAL}, ARM_SW_NONE);
        run_phase(PHASE_ITEMS, 20, 20, 1'b0);

        configure(16'($urandom_range(6)), 16'($urandom_range(6)), 16'($urandom_range(6)),
                  16'($urandom_range(6)), 12'hFFF, 8'($urandom), ARM_SW_HIGH);
        run_phase(PHASE_ITEMS, 0, 0, 1'b1);

        $display("Run covered %0d commands over %0d random phases plus a directed set;",
                 sent_total, phase_count);
        $display("%0d results checked, with long result hold-offs and idle pauses.",
                 checked);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run ceiling, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("Timeout with %0d results still awaited", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
